[src/cltk_pkg.sv]
// ----------------------------------------------------------------------------
// cltk_pkg
// Shared types and constants of the CNF literal tokenizer: scan modes,
// character codes, default widths and the result beat record.
// ----------------------------------------------------------------------------
package cltk_pkg;

  // default widths of the number accumulator and the length counters
  localparam int unsigned VarBitsDef = 24;
  localparam int unsigned LenBitsDef = 16;

  // result queue depth (power of two)
  localparam int unsigned OqDepth = 8;

  // fixed widths of the result fields
  localparam int unsigned OutVarW  = 24;
  localparam int unsigned OutLenW  = 16;
  localparam int unsigned OutDataW = 64;

  // character codes
  localparam logic [7:0] ChComment = 8'h63;  // 'c'
  localparam logic [7:0] ChProblem = 8'h70;  // 'p'
  localparam logic [7:0] ChMinus   = 8'h2D;  // '-'
  localparam logic [7:0] ChZero    = 8'h30;  // '0'
  localparam logic [7:0] ChNine    = 8'h39;  // '9'
  localparam logic [7:0] ChLf      = 8'h0A;  // newline
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;

  // scanner state
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_SKIP  = 2'd1,
    MODE_GAP   = 2'd2,
    MODE_NUM   = 2'd3
  } scan_mode_e;

  // result kinds
  localparam logic KindLiteral   = 1'b0;
  localparam logic KindClauseEnd = 1'b1;

  // one result beat
  typedef struct packed {
    logic               kind;
    logic [OutVarW-1:0] variable;
    logic               negated;
    logic [OutLenW-1:0] clause_length;
    logic [OutLenW-1:0] longest_clause;
    logic               last;
  } res_t;

endpackage

[src/cnf_literal_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// cnf_literal_tokenizer_core
// Scans DIMACS CNF text one byte per beat and emits literal and clause-end
// beats, tracking clause length and the longest clause seen.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Beat                       tuser               tlast
// s_axis    in   tdata[7:0] text byte       -                   end of input
// m_axis    out  tdata: variable, negated,  kind (1 clause end) last result
//                clause_length, longest                          of its byte
//
// One byte per cycle while the result queue has room; an end-of-input beat may emit two results.
// Each input byte passes through the input register and then the result queue
// register before its first result is offered.
// The result queue holds eight beats; input is taken while it holds four or
// fewer, which covers the byte in the input register and the next one.
// Reset (rst_ni low) clears scanner state and empties the queue.
//
module cnf_literal_tokenizer_core #(
  parameter int unsigned VAR_BITS = cltk_pkg::VarBitsDef,
  parameter int unsigned LEN_BITS = cltk_pkg::LenBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input byte stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] text_byte
  input  logic                          s_axis_tlast,   // end_of_input
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [23:0] variable, [24] negated, [40:25] clause_length,
  // [56:41] longest_clause, [63:57] zero
  output logic [cltk_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tuser,   // kind
  output logic                          m_axis_tlast    // last
);
  import cltk_pkg::*;

  localparam int unsigned AccW  = VAR_BITS + 4;
  localparam int unsigned PtrW  = $clog2(OqDepth);
  localparam int unsigned CntW  = $clog2(OqDepth + 1);
  localparam logic [VAR_BITS-1:0] VarMax = {VAR_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0] LenMax = {LEN_BITS{1'b1}};
  localparam logic [CntW-1:0] AcceptMax = CntW'(OqDepth - 4);

  // --------------------------------------------------------------------------
  // input register
  logic       stg_vld_q;
  logic [7:0] stg_byte_q;
  logic       stg_eoi_q;
  logic       in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= in_beat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      stg_byte_q <= s_axis_tdata;
      stg_eoi_q  <= s_axis_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // scanner state
  scan_mode_e          mode_q, mode_d;
  logic [VAR_BITS-1:0] num_q, num_d;
  logic                minus_q, minus_d;
  logic [LEN_BITS-1:0] clen_q, clen_d;
  logic [LEN_BITS-1:0] longest_q, longest_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_START;
      num_q     <= '0;
      minus_q   <= 1'b0;
      clen_q    <= '0;
      longest_q <= '0;
    end else begin
      mode_q    <= mode_d;
      num_q     <= num_d;
      minus_q   <= minus_d;
      clen_q    <= clen_d;
      longest_q <= longest_d;
    end
  end

  // --------------------------------------------------------------------------
  // byte classes and shared terms
  logic                is_white, is_digit, is_minus, is_cmt, num_nz, gap_like;
  logic [AccW-1:0]     acc;
  logic [VAR_BITS-1:0] acc_sat;
  logic [LEN_BITS-1:0] clen_inc, clen_end, longest_end;
  logic                do_lit, do_end, ce_emit;

  assign is_white = (stg_byte_q == ChSpace) ||
                    (stg_byte_q >= ChTab && stg_byte_q <= ChCr);
  assign is_digit = (stg_byte_q >= ChZero) && (stg_byte_q <= ChNine);
  assign is_minus = (stg_byte_q == ChMinus);
  assign is_cmt   = (stg_byte_q == ChComment) || (stg_byte_q == ChProblem);
  assign num_nz   = (num_q != '0);
  // byte where a number may begin
  assign gap_like = (mode_q == MODE_GAP) || ((mode_q == MODE_START) && !is_cmt);

  // num * 10 + digit, saturating at the top
  assign acc     = ({4'b0, num_q} << 3) + ({4'b0, num_q} << 1) + AccW'(stg_byte_q[3:0]);
  assign acc_sat = (acc[AccW-1:VAR_BITS] != '0) ? VarMax : acc[VAR_BITS-1:0];

  assign clen_inc = (clen_q == LenMax) ? clen_q : clen_q + 1'b1;

  // literal: end of input with a pending nonzero number, or a terminator
  assign do_lit = stg_vld_q && (mode_q == MODE_NUM) && num_nz &&
                  (stg_eoi_q || !is_digit);
  // clause end: end of input, bare non-digit, or a zero number
  assign do_end = stg_vld_q &&
                  (stg_eoi_q ||
                   (gap_like && !is_white && !is_minus && !is_digit) ||
                   ((mode_q == MODE_NUM) && !is_digit && !num_nz));

  assign clen_end    = do_lit ? clen_inc : clen_q;
  assign ce_emit     = do_end && (clen_end != '0);
  assign longest_end = (clen_end > longest_q) ? clen_end : longest_q;

  // --------------------------------------------------------------------------
  // next state
  always_comb begin
    mode_d    = mode_q;
    num_d     = num_q;
    minus_d   = minus_q;
    clen_d    = clen_q;
    longest_d = longest_q;
    if (stg_vld_q) begin
      if (stg_eoi_q) begin
        mode_d    = MODE_START;
        num_d     = '0;
        minus_d   = 1'b0;
        clen_d    = '0;
        longest_d = '0;
      end else if (do_end) begin
        mode_d    = MODE_START;
        num_d     = '0;
        minus_d   = 1'b0;
        clen_d    = '0;
        longest_d = ce_emit ? longest_end : longest_q;
      end else begin
        unique case (mode_q)
          MODE_SKIP: begin
            if (stg_byte_q == ChLf) mode_d = MODE_START;
          end
          MODE_NUM: begin
            if (is_digit) begin
              num_d = acc_sat;
            end else begin
              // nonzero number closed by its terminator
              clen_d  = clen_inc;
              num_d   = '0;
              minus_d = 1'b0;
              mode_d  = MODE_GAP;
            end
          end
          MODE_START, MODE_GAP: begin
            priority if (gap_like && is_digit) begin
              num_d  = VAR_BITS'(stg_byte_q[3:0]);
              mode_d = MODE_NUM;
            end else if (gap_like && is_minus) begin
              minus_d = 1'b1;
              mode_d  = MODE_GAP;
            end else if (gap_like) begin
              mode_d = MODE_GAP;   // whitespace
            end else begin
              mode_d = MODE_SKIP;  // comment or problem line
            end
          end
          default: mode_d = mode_q;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // result beats of the current byte
  res_t            lit_res, ce_res, res0, res1;
  logic [1:0]      n_push;
  logic [63:0]     var_ext;
  logic [31:0]     clen_ext, longest_ext, longest_q_ext;

  assign var_ext       = 64'(num_q);
  assign clen_ext      = 32'(clen_end);
  assign longest_ext   = 32'(longest_end);
  assign longest_q_ext = 32'(longest_q);

  always_comb begin
    lit_res.kind           = KindLiteral;
    lit_res.variable       = var_ext[OutVarW-1:0];
    lit_res.negated        = minus_q;
    lit_res.clause_length  = '0;
    lit_res.longest_clause = longest_q_ext[OutLenW-1:0];
    lit_res.last           = !ce_emit;

    ce_res.kind            = KindClauseEnd;
    ce_res.variable        = '0;
    ce_res.negated         = 1'b0;
    ce_res.clause_length   = clen_ext[OutLenW-1:0];
    ce_res.longest_clause  = longest_ext[OutLenW-1:0];
    ce_res.last            = 1'b1;

    res0   = do_lit ? lit_res : ce_res;
    res1   = ce_res;
    n_push = {1'b0, do_lit} + {1'b0, ce_emit};
  end

  // --------------------------------------------------------------------------
  // result queue
  res_t            oq_q [OqDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [CntW-1:0] cnt_q;
  logic            out_beat;

  assign wr_ptr_nx = wr_ptr_q + 1'b1;
  assign out_beat  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) oq_q[wr_ptr_q] <= res0;
    if (n_push == 2'd2) oq_q[wr_ptr_nx] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      if (out_beat) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + CntW'(n_push) - CntW'(out_beat);
    end
  end

  // --------------------------------------------------------------------------
  // ports
  res_t head;
  assign head          = oq_q[rd_ptr_q];
  assign s_axis_tready = (cnt_q <= AcceptMax);
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {7'b0, head.longest_clause, head.clause_length,
                          head.negated, head.variable};

endmodule

[src/cltk_checker.sv]
// ----------------------------------------------------------------------------
// cltk_checker
// Port-level checks of the CNF literal tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module cltk_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_i,
  input logic                          m_axis_tready_i,
  input logic [cltk_pkg::OutDataW-1:0] m_axis_tdata_i,
  input logic                          m_axis_tuser_i,
  input logic                          m_axis_tlast_i
);
  import cltk_pkg::*;

  // a clause end carries no variable and no sign, and is non-empty
  a_ce_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && m_axis_tuser_i == KindClauseEnd) |->
      (m_axis_tdata_i[24:0] == '0) && (m_axis_tdata_i[40:25] != '0))
    else $error("clause end beat with bad fields");

  // longest clause covers the clause that just ended
  a_ce_longest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && m_axis_tuser_i == KindClauseEnd) |->
      (m_axis_tdata_i[56:41] >= m_axis_tdata_i[40:25]))
    else $error("longest clause below clause length");

  // a literal has a nonzero variable and no length; padding stays zero
  a_lit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && m_axis_tuser_i == KindLiteral) |->
      (m_axis_tdata_i[23:0] != '0) && (m_axis_tdata_i[40:25] == '0) &&
      (m_axis_tdata_i[63:57] == '0))
    else $error("literal beat with bad fields");

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=>
      (m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i)))
    else $error("result beat dropped while stalled");

endmodule

bind cnf_literal_tokenizer_core cltk_checker u_cltk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_i(m_axis_tvalid),
  .m_axis_tready_i(m_axis_tready),
  .m_axis_tdata_i (m_axis_tdata),
  .m_axis_tuser_i (m_axis_tuser),
  .m_axis_tlast_i (m_axis_tlast)
);
